// ===== rtl/core/tcw_pkg.sv =====
// shared constants, codes and types of the text console writer
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_LOG2 = 3;
  localparam int TAB_STOP = 1 << TAB_LOG2;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam int IN_COL_W  = 7;
  localparam int IN_ROW_W  = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] MARK_CHAR    = 8'h5F;
  localparam logic [7:0] MARK_ATTR    = 8'h00;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TAB_CODE     = 8'd9;
  localparam logic [7:0] ATTR_RESET   = 8'd10;

  localparam logic [2:0] CUR_HOLD    = 3'd0;
  localparam logic [2:0] CUR_STEP    = 3'd1;
  localparam logic [2:0] CUR_NEWLINE = 3'd2;
  localparam logic [2:0] CUR_TAB     = 3'd3;
  localparam logic [2:0] CUR_SET     = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cur_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic              ovf;
  } cur_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic                 scrolled;
    logic [7:0]           cell_attr;
    logic [7:0]           cell_char;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
  } res_t;

endpackage

// ===== rtl/core/tcw_ram.sv =====
// generic single write port, single read port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tcw_cursor.sv =====
// print position register with advance, wrap and overflow arithmetic
module tcw_cursor (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::cur_cmd_t   cmd,
  output tcw_pkg::cur_stat_t  stat
);

  localparam int SUM_W = tcw_pkg::COL_W + 2;
  localparam int RSUM_W = tcw_pkg::ROW_W + 1;

  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcw_pkg::ADDR_W-1:0] offset;
  logic [tcw_pkg::TAB_LOG2:0] tab_adv;
  logic [SUM_W-1:0]           sum;
  logic [tcw_pkg::COL_W-1:0]  col_wrap;
  logic [1:0]                 row_inc;
  logic [RSUM_W-1:0]          row_sum;
  logic                       moving;
  logic                       ovf;

  always_comb begin
    offset  = tcw_pkg::ADDR_W'(int'(row_r) * tcw_pkg::COLUMNS + int'(col_r));
    tab_adv = (tcw_pkg::TAB_LOG2 + 1)'(tcw_pkg::TAB_STOP)
            - {1'b0, offset[tcw_pkg::TAB_LOG2-1:0]};
    if (cmd.op == tcw_pkg::CUR_TAB) begin
      sum = {2'b00, col_r} + SUM_W'(tab_adv);
    end else begin
      sum = {2'b00, col_r} + SUM_W'(1);
    end
    if (cmd.op == tcw_pkg::CUR_NEWLINE) begin
      col_wrap = '0;
      row_inc  = 2'd1;
    end else if (sum >= SUM_W'(2 * tcw_pkg::COLUMNS)) begin
      col_wrap = tcw_pkg::COL_W'(sum - SUM_W'(2 * tcw_pkg::COLUMNS));
      row_inc  = 2'd2;
    end else if (sum >= SUM_W'(tcw_pkg::COLUMNS)) begin
      col_wrap = tcw_pkg::COL_W'(sum - SUM_W'(tcw_pkg::COLUMNS));
      row_inc  = 2'd1;
    end else begin
      col_wrap = tcw_pkg::COL_W'(sum);
      row_inc  = 2'd0;
    end
    row_sum = {1'b0, row_r} + RSUM_W'(row_inc);
    moving  = (cmd.op == tcw_pkg::CUR_STEP) || (cmd.op == tcw_pkg::CUR_TAB)
           || (cmd.op == tcw_pkg::CUR_NEWLINE);
    ovf     = moving && (row_sum >= RSUM_W'(tcw_pkg::ROWS));

    col_nxt = col_r;
    row_nxt = row_r;
    case (cmd.op)
      tcw_pkg::CUR_STEP, tcw_pkg::CUR_TAB, tcw_pkg::CUR_NEWLINE: begin
        if (ovf) begin
          // scroll leaves the cursor at the start of the last row
          col_nxt = '0;
          row_nxt = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        end else begin
          col_nxt = col_wrap;
          row_nxt = tcw_pkg::ROW_W'(row_sum);
        end
      end
      tcw_pkg::CUR_SET: begin
        col_nxt = cmd.col;
        row_nxt = cmd.row;
      end
      default: begin
        col_nxt = col_r;
        row_nxt = row_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign stat.col  = col_r;
  assign stat.row  = row_r;
  assign stat.addr = offset;
  assign stat.ovf  = ovf;

endmodule

// ===== rtl/core/tcw_seq.sv =====
// sequencer: sweeps, scan and cell accesses over the screen ram
module tcw_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [7:0]                   in_char,
  input  logic [tcw_pkg::IN_COL_W-1:0] in_col,
  input  logic [tcw_pkg::IN_ROW_W-1:0] in_row,
  input  logic [7:0]                   def_attr,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tcw_pkg::res_t                res,
  output tcw_pkg::cur_cmd_t            cur_cmd,
  input  tcw_pkg::cur_stat_t           cur_stat,
  output tcw_pkg::ram_req_t            ram_req,
  input  tcw_pkg::cell_t               ram_rdata
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PUT    = 4'd2;
  localparam logic [3:0] S_SCROLL = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_CLEAR  = 4'd5;
  localparam logic [3:0] S_DRAW   = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam int CNT_W  = tcw_pkg::CNT_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int KEEP   = tcw_pkg::CELLS - tcw_pkg::COLUMNS;

  logic [3:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      scr_r, scr_nxt;
  logic [1:0]                op_r, op_nxt;
  logic [7:0]                ch_r, ch_nxt;
  logic [tcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [ADDR_W-1:0]         tgt;
  logic [ADDR_W-1:0]         idx_a;
  logic [ADDR_W-1:0]         idx_m1;
  tcw_pkg::cell_t            blank;
  logic                      mark_hit;

  always_comb begin
    tgt      = ADDR_W'(int'(row_r) * tcw_pkg::COLUMNS + int'(col_r));
    idx_a    = idx_r[ADDR_W-1:0];
    idx_m1   = ADDR_W'(idx_r - CNT_W'(1));
    blank    = '{ch: tcw_pkg::BLANK_CHAR, attr: def_attr};
    mark_hit = (ram_rdata.ch == tcw_pkg::MARK_CHAR) && (ram_rdata.attr == tcw_pkg::MARK_ATTR);

    state_nxt   = state_r;
    idx_nxt     = idx_r;
    scr_nxt     = scr_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    ram_req     = '0;
    cur_cmd.op  = tcw_pkg::CUR_HOLD;
    cur_cmd.col = col_r;
    cur_cmd.row = row_r;

    case (state_r)
      S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_a;
        ram_req.wdata = '0;
        if (idx_r == CNT_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          ch_nxt  = in_char;
          idx_nxt = '0;
          scr_nxt = 1'b0;
          if (int'(in_col) >= tcw_pkg::COLUMNS) begin
            col_nxt = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
          end else begin
            col_nxt = tcw_pkg::COL_W'(in_col);
          end
          if (int'(in_row) >= tcw_pkg::ROWS) begin
            row_nxt = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
          end else begin
            row_nxt = tcw_pkg::ROW_W'(in_row);
          end
          case (in_op)
            tcw_pkg::OP_PUT: state_nxt = S_PUT;
            tcw_pkg::OP_SET: state_nxt = S_SCAN;
            tcw_pkg::OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_READ;
          endcase
        end
      end
      S_PUT: begin
        if (ch_r == tcw_pkg::NEWLINE_CODE) begin
          cur_cmd.op = tcw_pkg::CUR_NEWLINE;
        end else if (ch_r == tcw_pkg::TAB_CODE) begin
          cur_cmd.op = tcw_pkg::CUR_TAB;
        end else begin
          cur_cmd.op    = tcw_pkg::CUR_STEP;
          ram_req.we    = 1'b1;
          ram_req.waddr = cur_stat.addr;
          ram_req.wdata = '{ch: ch_r, attr: def_attr};
        end
        if (cur_stat.ovf) begin
          scr_nxt   = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the previous read one slot back
        if (idx_r < CNT_W'(KEEP)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(idx_r + CNT_W'(tcw_pkg::COLUMNS));
        end
        if (idx_r != '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_m1;
          ram_req.wdata = (idx_r <= CNT_W'(KEEP)) ? ram_rdata : blank;
        end
        if (idx_r == CNT_W'(tcw_pkg::CELLS)) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SCAN: begin
        if (idx_r < CNT_W'(tcw_pkg::CELLS)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_a;
        end
        if ((idx_r != '0) && mark_hit) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_m1;
          ram_req.wdata = blank;
          state_nxt     = S_DRAW;
        end else if (idx_r == CNT_W'(tcw_pkg::CELLS)) begin
          state_nxt = S_DRAW;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_a;
        ram_req.wdata = blank;
        if (idx_r == CNT_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = S_DRAW;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_DRAW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = tgt;
        ram_req.wdata = '{ch: tcw_pkg::MARK_CHAR, attr: tcw_pkg::MARK_ATTR};
        cur_cmd.op    = tcw_pkg::CUR_SET;
        state_nxt     = S_DONE;
      end
      S_READ: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = tgt;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      idx_r   <= '0;
      scr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      scr_r   <= scr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ch_r  <= ch_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.cursor_col = tcw_pkg::OUT_COL_W'(cur_stat.col);
    res.cursor_row = tcw_pkg::OUT_ROW_W'(cur_stat.row);
    res.cell_char  = (op_r == tcw_pkg::OP_READ) ? ram_rdata.ch : 8'd0;
    res.cell_attr  = (op_r == tcw_pkg::OP_READ) ? ram_rdata.attr : 8'd0;
    res.scrolled   = scr_r;
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// top level of the text console writer: ports, config register, output register
//
// Usage: items enter on the in_ stream (tuser = opcode, tdata = char, col, row)
// and each one gives exactly one result item on the out_ stream (cursor column
// and row, cell char and attribute for read cell, scroll flag). in_tready is
// high only while the sequencer is idle; one item is worked on at a time.
// Before its result is loaded into the output register, an item passes these
// sequencer states: put character, newline or tab: put, then a scroll sweep
// on overflow; set cursor: a scan for the first cursor mark, then draw;
// clear screen: a clear sweep, then draw; read cell: read.
// Scroll, clear and the mark scan walk the screen ram one cell per cycle
// through its single read and single write port.
// The output register holds a result until out_tready takes it; a new item is
// accepted meanwhile, and its result waits in the sequencer if the register is
// still full. After reset a clearing pass writes zeros to all CELLS cells
// with in_tready low; cfg_we writes are taken at any time and the default
// attribute resets to 10.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode
  input  logic [23:0] in_tdata,   // char_code[7:0], col[14:8], row[19:15], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                  // cell_attr[27:20], scrolled[28], zero pad
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int RES_W = $bits(tcw_pkg::res_t);

  logic [7:0]          attr_r;
  logic                out_valid_r;
  tcw_pkg::res_t       out_data_r;

  logic                res_valid;
  logic                res_ready;
  tcw_pkg::res_t       res;
  tcw_pkg::cur_cmd_t   cur_cmd;
  tcw_pkg::cur_stat_t  cur_stat;
  tcw_pkg::ram_req_t   ram_req;
  tcw_pkg::cell_t      ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  tcw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_char   (in_tdata[7:0]),
    .in_col    (in_tdata[14:8]),
    .in_row    (in_tdata[19:15]),
    .def_attr  (attr_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cur_cmd   (cur_cmd),
    .cur_stat  (cur_stat),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  tcw_cursor u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cur_cmd),
    .stat  (cur_stat)
  );

  tcw_ram #(
    .WIDTH ($bits(tcw_pkg::cell_t)),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(32 - RES_W)'(0), out_data_r};

endmodule
